@@ hw/rtl/tdc_pkg.sv @@
package tdc_pkg;

  // widths of the sample, the duty and the breakpoint file
  localparam int AdcBits    = 12;
  localparam int DutyBits   = 16;
  localparam int NumPts     = 4;
  localparam int NumRegs    = 2 * NumPts;
  localparam int CfgIdxBits = $clog2(NumRegs);
  localparam int PtIdxBits  = $clog2(NumPts);

  // product of duty step and offset, and quotient bits of the divider
  localparam int NumBits = AdcBits + DutyBits;
  localparam int QBits   = DutyBits;

  // queue between classifier and divider
  localparam int QueueDepth = 2;
  localparam int PtrBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);

  // fixed duty at each breakpoint, index 0 is the hottest point
  localparam logic [NumPts-1:0][DutyBits-1:0] DutyAt = {
    16'd65535, 16'd39321, 16'd13107, 16'd0
  };

  // breakpoint reset values, entries 0..3 led set, 4..7 board set
  localparam logic [NumRegs-1:0][AdcBits-1:0] RegReset = {
    12'd2000, 12'd1600, 12'd1200, 12'd800,
    12'd2000, 12'd1600, 12'd1200, 12'd800
  };

  typedef logic [NumRegs-1:0][AdcBits-1:0] points_t;

  // classified request handed to the divider
  typedef struct packed {
    logic [NumBits-1:0]  num;
    logic [AdcBits-1:0]  width;
    logic [DutyBits-1:0] base;
  } item_t;

endpackage

@@ hw/rtl/tdc_front.sv @@
module tdc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdc_pkg::points_t          points_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tdc_pkg::AdcBits-1:0] adc_reading_i,
  input  logic                      use_led_sensor_i,
  output logic                      item_valid_o,
  input  logic                      item_stall_i,
  output tdc_pkg::item_t            item_o
);
  import tdc_pkg::*;

  logic                           adv;
  logic [NumPts-1:0][AdcBits-1:0] pt;
  logic [PtIdxBits-1:0]           lo, hi;
  logic [AdcBits-1:0]             pt_lo, pt_hi;
  logic                           direct;

  logic                f1_valid_q;
  logic [DutyBits-1:0] f1_base_q, f1_base_d;
  logic [DutyBits-1:0] f1_diff_q, f1_diff_d;
  logic [AdcBits-1:0]  f1_off_q, f1_off_d;
  logic [AdcBits-1:0]  f1_width_q, f1_width_d;

  logic  f2_valid_q;
  item_t f2_q, f2_d;

  // whole front moves together when the queue can take the last stage
  assign adv        = !f2_valid_q || !item_stall_i;
  assign in_stall_o = !adv;

  // breakpoint set select
  always_comb begin
    for (int k = 0; k < NumPts; k++) begin
      pt[k] = use_led_sensor_i ? points_i[k] : points_i[NumPts + k];
    end
  end

  // segment search and clamps
  always_comb begin
    if (pt[1] == adc_reading_i) begin
      lo = PtIdxBits'(1); hi = PtIdxBits'(1);
    end else if (pt[1] > adc_reading_i) begin
      lo = PtIdxBits'(0); hi = PtIdxBits'(1);
    end else if (pt[2] == adc_reading_i) begin
      lo = PtIdxBits'(2); hi = PtIdxBits'(2);
    end else if (pt[2] > adc_reading_i) begin
      lo = PtIdxBits'(1); hi = PtIdxBits'(2);
    end else begin
      lo = PtIdxBits'(2); hi = PtIdxBits'(3);
    end
    if (pt[0] >= adc_reading_i) begin
      lo = PtIdxBits'(0); hi = PtIdxBits'(0);
    end
    if (pt[NumPts-1] <= adc_reading_i) begin
      lo = PtIdxBits'(NumPts-1); hi = PtIdxBits'(NumPts-1);
    end
  end

  // segment width, offset and duty step; flat points divide 0 by 1
  always_comb begin
    pt_lo  = pt[lo];
    pt_hi  = pt[hi];
    direct = (lo == hi) || (pt_hi <= pt_lo) || (adc_reading_i <= pt_lo);
    f1_base_d = DutyAt[lo];
    if (direct) begin
      f1_diff_d  = '0;
      f1_off_d   = '0;
      f1_width_d = AdcBits'(1);
    end else begin
      f1_diff_d  = DutyAt[hi] - DutyAt[lo];
      f1_off_d   = adc_reading_i - pt_lo;
      f1_width_d = pt_hi - pt_lo;
    end
  end

  // numerator product
  always_comb begin
    f2_d.num   = NumBits'(f1_diff_q) * NumBits'(f1_off_q);
    f2_d.width = f1_width_q;
    f2_d.base  = f1_base_q;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_base_q  <= f1_base_d;
      f1_diff_q  <= f1_diff_d;
      f1_off_q   <= f1_off_d;
      f1_width_q <= f1_width_d;
      f2_q       <= f2_d;
    end
  end

  assign item_valid_o = f2_valid_q;
  assign item_o       = f2_q;

  // a stalled product holds
  a_f2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f2_valid_q && item_stall_i |=> f2_valid_q && $stable(f2_q))
    else $error("front product changed while stalled");

  // the divider never sees a zero width
  a_width_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f2_valid_q |-> f2_q.width != '0)
    else $error("zero segment width sent to divider");

endmodule

@@ hw/rtl/tdc_queue.sv @@
module tdc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_stall_o,
  input  tdc_pkg::item_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_stall_i,
  output tdc_pkg::item_t pop_data_o
);
  import tdc_pkg::*;

  item_t               data_q [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  count_q;
  logic                full, push, pop;

  assign full         = (count_q == CntBits'(QueueDepth));
  assign push         = push_valid_i && !full;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign push_stall_o = full;
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = data_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      if (push && !pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) data_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ hw/rtl/tdc_back.sv @@
module tdc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_stall_o,
  input  tdc_pkg::item_t               item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tdc_pkg::DutyBits-1:0] duty_limit_o
);
  import tdc_pkg::*;

  logic adv;

  // divider stage registers, one quotient bit per stage
  logic                st_valid_q [QBits];
  logic [AdcBits-1:0]  st_rem_q   [QBits];
  logic [QBits-1:0]    st_low_q   [QBits];
  logic [QBits-1:0]    st_quo_q   [QBits];
  logic [AdcBits-1:0]  st_width_q [QBits];
  logic [DutyBits-1:0] st_base_q  [QBits];

  logic                st_valid_d [QBits];
  logic [AdcBits-1:0]  st_rem_d   [QBits];
  logic [QBits-1:0]    st_low_d   [QBits];
  logic [QBits-1:0]    st_quo_d   [QBits];
  logic [AdcBits-1:0]  st_width_d [QBits];
  logic [DutyBits-1:0] st_base_d  [QBits];

  logic                out_valid_q;
  logic [DutyBits-1:0] duty_q, duty_d;

  // pipeline moves as a whole when the output register is free
  assign adv          = !out_valid_q || !out_stall_i;
  assign item_stall_o = !adv;

  // restoring division step per stage
  always_comb begin
    for (int s = 0; s < QBits; s++) begin
      logic               v_in;
      logic [AdcBits-1:0] rem_in, w_in;
      logic [QBits-1:0]   low_in, quo_in;
      logic [DutyBits-1:0] base_in;
      logic [AdcBits:0]   trial;
      logic               ge;
      if (s == 0) begin
        v_in    = item_valid_i;
        rem_in  = item_i.num[NumBits-1 -: AdcBits];
        low_in  = item_i.num[QBits-1:0];
        quo_in  = '0;
        w_in    = item_i.width;
        base_in = item_i.base;
      end else begin
        v_in    = st_valid_q[s-1];
        rem_in  = st_rem_q[s-1];
        low_in  = st_low_q[s-1];
        quo_in  = st_quo_q[s-1];
        w_in    = st_width_q[s-1];
        base_in = st_base_q[s-1];
      end
      trial          = {rem_in, low_in[QBits-1]};
      ge             = (trial >= {1'b0, w_in});
      st_valid_d[s]  = v_in;
      st_rem_d[s]    = ge ? AdcBits'(trial - {1'b0, w_in}) : trial[AdcBits-1:0];
      st_low_d[s]    = {low_in[QBits-2:0], 1'b0};
      st_quo_d[s]    = {quo_in[QBits-2:0], ge};
      st_width_d[s]  = w_in;
      st_base_d[s]   = base_in;
    end
  end

  // lower duty plus quotient
  assign duty_d = st_base_q[QBits-1] + st_quo_q[QBits-1];

  // valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QBits; s++) st_valid_q[s] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < QBits; s++) st_valid_q[s] <= st_valid_d[s];
      out_valid_q <= st_valid_q[QBits-1];
    end
  end

  // payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < QBits; s++) begin
        st_rem_q[s]   <= st_rem_d[s];
        st_low_q[s]   <= st_low_d[s];
        st_quo_q[s]   <= st_quo_d[s];
        st_width_q[s] <= st_width_d[s];
        st_base_q[s]  <= st_base_d[s];
      end
      duty_q <= duty_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign duty_limit_o = duty_q;

  // the quotient must fit: top numerator bits stay below the width
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && adv |-> item_i.num[NumBits-1 -: AdcBits] < item_i.width)
    else $error("divider quotient overflows");

  // a result appears only when the last stage held a request
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_valid_q[QBits-1]))
    else $error("result without a request in the divider");

endmodule

@@ hw/rtl/thermal_derating_curve.sv @@
// pipeline: two classify stages, one queue slot, 16 divider stages and an
// output register; one request per cycle while out_stall_i is low, set by
// the 16-stage pipelined divider
// a 2-entry queue lets the classifier keep accepting while the divider stalls
// reset: asynchronous active low, breakpoints return to 800/1200/1600/2000
// for both sets and all pipeline and queue contents are dropped
module thermal_derating_curve (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tdc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [tdc_pkg::AdcBits-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tdc_pkg::AdcBits-1:0]     adc_reading_i,
  input  logic                            use_led_sensor_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tdc_pkg::DutyBits-1:0]    duty_limit_o
);
  import tdc_pkg::*;

  points_t points_q;

  logic  fq_valid, fq_stall;
  item_t fq_data;
  logic  qb_valid, qb_stall;
  item_t qb_data;

  // breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= RegReset;
    end else if (cfg_we_i) begin
      points_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // classifier
  tdc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .points_i         (points_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .adc_reading_i    (adc_reading_i),
    .use_led_sensor_i (use_led_sensor_i),
    .item_valid_o     (fq_valid),
    .item_stall_i     (fq_stall),
    .item_o           (fq_data)
  );

  // decoupling queue
  tdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_stall_i  (qb_stall),
    .pop_data_o   (qb_data)
  );

  // divider and output register
  tdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (qb_valid),
    .item_stall_o (qb_stall),
    .item_i       (qb_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duty_limit_o (duty_limit_o)
  );

endmodule
